// ===== hdl/llcd_pkg.sv =====
// Package for the liquid level contact detector.
// Holds constants, register map codes and the structs shared by the step logic and the top level.
// No dependencies.
package llcd_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [SampleW-1:0] DisabledLimit = 16'd5000;
  localparam logic [SampleW-1:0] ClearMargin   = 16'd100;
  localparam logic [CountW-1:0]  CountMax      = 8'd255;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    RegDetectEnable   = 3'd0,
    RegFilterFloor    = 3'd1,
    RegLevelThreshold = 3'd2,
    RegSlopeStep      = 3'd3,
    RegLevelLimit     = 3'd4,
    RegSlopeLimit     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    SrcNone  = 2'd0,
    SrcLevel = 2'd1,
    SrcSlope = 2'd2
  } trig_src_e;

  typedef enum logic {
    OpProcess = 1'b0,
    OpClear   = 1'b1
  } op_e;

  typedef struct packed {
    logic               detect_enable;
    logic [SampleW-1:0] filter_floor;
    logic [SampleW-1:0] level_threshold;
    logic [SampleW-1:0] slope_step;
    logic [CountW-1:0]  level_count_limit;
    logic [CountW-1:0]  slope_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] filtered_value;
    logic [CountW-1:0]  level_count;
    logic [CountW-1:0]  slope_count;
    logic [SampleW-1:0] slope_base;
  } det_state_t;

  typedef struct packed {
    logic               detected;
    trig_src_e          trigger_source;
    logic [SampleW-1:0] filtered_level;
  } det_result_t;

endpackage

// ===== hdl/llcd_step.sv =====
// Per-sample step logic: filter, level check and slope check.
// Pure combinational next-state and result computation; depends on llcd_pkg.
module llcd_step (
  input  llcd_pkg::cfg_t        cfg_i,
  input  llcd_pkg::det_state_t  state_i,
  input  logic                  operation_i,
  input  logic [15:0]           probe_sample_i,
  output llcd_pkg::det_state_t  state_o,
  output llcd_pkg::det_result_t result_o
);
  import llcd_pkg::*;

  logic [SampleW-1:0] thresh;
  logic [SampleW-1:0] step;
  logic [SampleW-1:0] filt;
  logic [SampleW:0]   avg_sum;
  logic [SampleW:0]   lvl_margin;
  logic [SampleW-1:0] base_minus_filt;
  logic [SampleW-1:0] filt_minus_base;
  logic [CountW-1:0]  lvl_cnt;
  logic [CountW-1:0]  slp_cnt;
  logic [SampleW-1:0] slp_base;
  logic               lvl_fire;
  logic               slp_fire;

  assign thresh = cfg_i.detect_enable ? cfg_i.level_threshold : DisabledLimit;
  assign step   = cfg_i.detect_enable ? cfg_i.slope_step : DisabledLimit;

  assign avg_sum = {1'b0, state_i.filtered_value} + {1'b0, probe_sample_i};

  always_comb begin
    if (probe_sample_i < cfg_i.filter_floor) begin
      filt = '0;
    end else if (state_i.filtered_value == '0) begin
      filt = probe_sample_i;
    end else begin
      filt = avg_sum[SampleW:1];
    end
  end

  // level check
  assign lvl_margin = {1'b0, filt} + {1'b0, ClearMargin};

  always_comb begin
    lvl_cnt = state_i.level_count;
    if (filt >= thresh) begin
      lvl_cnt = (state_i.level_count == CountMax) ? CountMax
                                                  : state_i.level_count + CountW'(1);
    end else if (state_i.level_count != '0 && lvl_margin < {1'b0, thresh}) begin
      lvl_cnt = '0;
    end
  end

  assign lvl_fire = (lvl_cnt >= cfg_i.level_count_limit);

  // slope check, its result only used when the level check stays quiet
  assign base_minus_filt = state_i.slope_base - filt;
  assign filt_minus_base = filt - state_i.slope_base;

  always_comb begin
    slp_cnt  = state_i.slope_count;
    slp_base = state_i.slope_base;
    if (state_i.slope_count == '0) begin
      if (filt > step) begin
        slp_cnt  = CountW'(1);
        slp_base = filt;
      end
    end else if (filt < state_i.slope_base) begin
      if (base_minus_filt > ClearMargin) begin
        slp_cnt  = '0;
        slp_base = '0;
      end
    end else if (filt_minus_base >= step) begin
      slp_cnt  = (state_i.slope_count == CountMax) ? CountMax
                                                   : state_i.slope_count + CountW'(1);
      slp_base = filt;
    end
  end

  assign slp_fire = (slp_cnt >= cfg_i.slope_count_limit);

  always_comb begin
    if (operation_i == OpClear) begin
      state_o  = '0;
      result_o = '{detected: 1'b0, trigger_source: SrcNone, filtered_level: '0};
    end else begin
      state_o.filtered_value = filt;
      state_o.level_count    = lvl_cnt;
      if (lvl_fire) begin
        state_o.slope_count = state_i.slope_count;
        state_o.slope_base  = state_i.slope_base;
        result_o = '{detected: 1'b1, trigger_source: SrcLevel, filtered_level: filt};
      end else begin
        state_o.slope_count = slp_cnt;
        state_o.slope_base  = slp_base;
        if (slp_fire) begin
          result_o = '{detected: 1'b1, trigger_source: SrcSlope, filtered_level: filt};
        end else begin
          result_o = '{detected: 1'b0, trigger_source: SrcNone, filtered_level: filt};
        end
      end
    end
  end

endmodule

// ===== hdl/liquid_level_contact_detector.sv =====
// Top level of the liquid level contact detector: APB registers, input register,
// detection state and result register. Depends on llcd_pkg and llcd_step.
//
//  Channel  | Signals                                       | Dir
//  ---------+-----------------------------------------------+----
//  in       | in_valid_i, in_ready_o, operation_i,           | in
//           | probe_sample_i                                |
//  out      | out_valid_o, out_ready_i, detected_o,          | out
//           | trigger_source_o, filtered_level_o            |
//  apb      | psel, penable, pwrite, paddr, pwdata,          | cfg
//           | prdata, pready                                |
//
// One transaction per cycle sustained while the output is not stalled; an accepted input
// is loaded into the input register, and the step logic result goes into the result register
// when the output side is free, from which it leaves on the out channel.
// The detection state updates in the same cycle as the result register loads, so
// consecutive samples need no bubbles. Reset clears state, valids and config registers to defaults.
// A stalled output holds the input register; in_ready_o drops only when both stages are full.
module liquid_level_contact_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [15:0]                   probe_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          detected_o,
  output logic [1:0]                    trigger_source_o,
  output logic [15:0]                   filtered_level_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llcd_pkg::ApbAddrW-1:0] paddr,
  input  logic [llcd_pkg::ApbDataW-1:0] pwdata,
  output logic [llcd_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import llcd_pkg::*;

  cfg_t        cfg_q;
  det_state_t  state_q, state_d;
  det_result_t res_d, res_q;
  logic        s1_valid_q;
  logic        s1_op_q;
  logic [SampleW-1:0] s1_sample_q;
  logic        out_valid_q;
  logic        s1_fire;
  logic        in_fire;
  logic        cfg_write;
  reg_idx_e    reg_idx;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{detect_enable: 1'b0, filter_floor: '0,
                 level_threshold: DisabledLimit, slope_step: DisabledLimit,
                 level_count_limit: CountW'(3), slope_count_limit: CountW'(3)};
    end else if (cfg_write) begin
      case (reg_idx)
        RegDetectEnable:   cfg_q.detect_enable     <= pwdata[0];
        RegFilterFloor:    cfg_q.filter_floor      <= pwdata[SampleW-1:0];
        RegLevelThreshold: cfg_q.level_threshold   <= pwdata[SampleW-1:0];
        RegSlopeStep:      cfg_q.slope_step        <= pwdata[SampleW-1:0];
        RegLevelLimit:     cfg_q.level_count_limit <= pwdata[CountW-1:0];
        RegSlopeLimit:     cfg_q.slope_count_limit <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegDetectEnable:   prdata = ApbDataW'(cfg_q.detect_enable);
      RegFilterFloor:    prdata = ApbDataW'(cfg_q.filter_floor);
      RegLevelThreshold: prdata = ApbDataW'(cfg_q.level_threshold);
      RegSlopeStep:      prdata = ApbDataW'(cfg_q.slope_step);
      RegLevelLimit:     prdata = ApbDataW'(cfg_q.level_count_limit);
      RegSlopeLimit:     prdata = ApbDataW'(cfg_q.slope_count_limit);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q     <= operation_i;
      s1_sample_q <= probe_sample_i;
    end
  end

  llcd_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .operation_i    (s1_op_q),
    .probe_sample_i (s1_sample_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign detected_o       = res_q.detected;
  assign trigger_source_o = res_q.trigger_source;
  assign filtered_level_o = res_q.filtered_level;

  // ---------------- assertions ----------------
  a_src_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.trigger_source == SrcNone ||
                     res_q.trigger_source == SrcLevel ||
                     res_q.trigger_source == SrcSlope))
    else $error("illegal trigger source");

  a_det_matches_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.detected == (res_q.trigger_source != SrcNone)))
    else $error("detected flag disagrees with trigger source");

  a_clear_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_op_q == OpClear) |=> (state_q == '0 && res_q.filtered_level == '0))
    else $error("clear did not zero state");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without full pipeline");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(state_q))
    else $error("state changed without a processed transaction");

endmodule

// ===== dv/llcd_checker.sv =====
// Checker for the liquid level contact detector: watches the APB port and both channels,
// keeps its own copy of the registers and detection state, and compares every result.
// Depends on llcd_pkg.
module llcd_checker
  import llcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                operation_i,
  input  logic [15:0]         probe_sample_i,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic                detected_o,
  input  logic [1:0]          trigger_source_o,
  input  logic [15:0]         filtered_level_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  input  logic                pready,
  output int unsigned         err_count_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam cfg_t CfgReset = '{
    detect_enable:     1'b0,
    filter_floor:      16'd0,
    level_threshold:   16'd5000,
    slope_step:        16'd5000,
    level_count_limit: 8'd3,
    slope_count_limit: 8'd3
  };

  cfg_t        cfg_shadow;
  det_state_t  det_state;
  det_result_t pending_detections[$];

  // Advances the detection state by one transaction and returns the result it yields.
  function automatic det_result_t next_detection(op_e op, logic [15:0] sample);
    logic [15:0] thr;
    logic [15:0] step;
    logic [16:0] sum;
    det_result_t res;
    res.trigger_source = SrcNone;
    if (op == OpClear) begin
      det_state = '0;
    end else begin
      if (sample < cfg_shadow.filter_floor) begin
        det_state.filtered_value = '0;
      end else if (det_state.filtered_value == '0) begin
        det_state.filtered_value = sample;
      end else begin
        sum = {1'b0, det_state.filtered_value} + {1'b0, sample};
        det_state.filtered_value = sum[16:1];
      end
      thr  = cfg_shadow.detect_enable ? cfg_shadow.level_threshold : DisabledLimit;
      step = cfg_shadow.detect_enable ? cfg_shadow.slope_step : DisabledLimit;

      if (det_state.filtered_value >= thr) begin
        if (det_state.level_count != CountMax) det_state.level_count++;
      end else if (det_state.level_count != '0 &&
                   ({1'b0, det_state.filtered_value} + {1'b0, ClearMargin}) < {1'b0, thr}) begin
        det_state.level_count = '0;
      end

      if (det_state.level_count >= cfg_shadow.level_count_limit) begin
        res.trigger_source = SrcLevel;
      end else begin
        // slope check only runs when the level check stays quiet
        if (det_state.slope_count == '0) begin
          if (det_state.filtered_value > step) begin
            det_state.slope_count = 8'd1;
            det_state.slope_base  = det_state.filtered_value;
          end
        end else if (det_state.filtered_value < det_state.slope_base) begin
          if ((det_state.slope_base - det_state.filtered_value) > ClearMargin) begin
            det_state.slope_count = '0;
            det_state.slope_base  = '0;
          end
        end else if ((det_state.filtered_value - det_state.slope_base) >= step) begin
          if (det_state.slope_count != CountMax) det_state.slope_count++;
          det_state.slope_base = det_state.filtered_value;
        end
        if (det_state.slope_count >= cfg_shadow.slope_count_limit) res.trigger_source = SrcSlope;
      end
    end
    res.detected       = (res.trigger_source != SrcNone);
    res.filtered_level = det_state.filtered_value;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    det_result_t want;
    if (!rst_ni) begin
      cfg_shadow = CfgReset;
      det_state  = '0;
      pending_detections.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // results first: a transaction accepted at this edge cannot leave at the same edge
      if (out_valid_o && out_ready_i) begin
        if (pending_detections.size() == 0) begin
          err_count_o++;
          $error("unexpected result: detected %0d, trigger_source %0d, filtered_level %0d",
                 detected_o, trigger_source_o, filtered_level_o);
        end else begin
          want = pending_detections.pop_front();
          if (detected_o !== want.detected) begin
            err_count_o++;
            $error("detected: expected %0d, got %0d", want.detected, detected_o);
          end
          if (trigger_source_o !== want.trigger_source) begin
            err_count_o++;
            $error("trigger_source: expected %0d, got %0d", want.trigger_source,
                   trigger_source_o);
          end
          if (filtered_level_o !== want.filtered_level) begin
            err_count_o++;
            $error("filtered_level: expected %0d, got %0d", want.filtered_level,
                   filtered_level_o);
          end
        end
      end

      if (in_valid_i && in_ready_o)
        pending_detections.push_back(next_detection(op_e'(operation_i), probe_sample_i));

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ApbAddrW-1:2]))
          RegDetectEnable:   cfg_shadow.detect_enable     = pwdata[0];
          RegFilterFloor:    cfg_shadow.filter_floor      = pwdata[15:0];
          RegLevelThreshold: cfg_shadow.level_threshold   = pwdata[15:0];
          RegSlopeStep:      cfg_shadow.slope_step        = pwdata[15:0];
          RegLevelLimit:     cfg_shadow.level_count_limit = pwdata[7:0];
          RegSlopeLimit:     cfg_shadow.slope_count_limit = pwdata[7:0];
          default: ;
        endcase
      end

      pending_o = pending_detections.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the liquid level contact detector: clock, reset, APB register
// writes, sample stimulus and output back-pressure. Depends on llcd_pkg,
// llcd_checker and liquid_level_contact_detector.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import llcd_pkg::*;

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned NumPhases     = 24;
  localparam int unsigned PhaseItems    = 45;
  localparam int unsigned SatItems      = 280;
  localparam int unsigned HoldOffPhase  = 4;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned StuckLimit    = 3000;
  localparam int unsigned NumRegs       = int'(RegSlopeLimit) + 1;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                operation_i    = OpProcess;
  logic [15:0]         probe_sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                detected_o;
  logic [1:0]          trigger_source_o;
  logic [15:0]         filtered_level_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [ApbAddrW-1:0] paddr          = '0;
  logic [ApbDataW-1:0] pwdata         = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned stuck_cycles = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;
  bit          hold_off_req = 1'b0;
  int          ramp_level   = 0;
  cfg_t        cfg_now      = '{1'b0, 16'd0, 16'd5000, 16'd5000, 8'd3, 8'd3};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  liquid_level_contact_detector i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .probe_sample_i   (probe_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .detected_o       (detected_o),
    .trigger_source_o (trigger_source_o),
    .filtered_level_o (filtered_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  llcd_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .probe_sample_i   (probe_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .detected_o       (detected_o),
    .trigger_source_o (trigger_source_o),
    .filtered_level_o (filtered_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .err_count_o      (fail_count),
    .pending_o        (results_pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(95, 105));
      3:       return 16'($urandom);
      default: return 16'($urandom_range(500, 20000));
    endcase
  endfunction

  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.detect_enable = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0, 1, 2: c.filter_floor = 16'd0;
      3:       c.filter_floor = 16'($urandom);
      default: c.filter_floor = 16'($urandom_range(0, 3000));
    endcase
    c.level_threshold   = pick_level();
    c.slope_step        = pick_level();
    c.level_count_limit = pick_limit();
    c.slope_count_limit = pick_limit();
    return c;
  endfunction

  // ramps drive the slope check, plateaus near the threshold drive the level check, other styles are random
  function automatic logic [15:0] next_sample(int unsigned style);
    int step;
    int thr;
    int v;
    step = cfg_now.detect_enable ? int'(cfg_now.slope_step) : int'(DisabledLimit);
    thr  = cfg_now.detect_enable ? int'(cfg_now.level_threshold) : int'(DisabledLimit);
    if (cfg_now.filter_floor != 0 && $urandom_range(0, 11) == 0)
      return 16'($urandom_range(0, int'(cfg_now.filter_floor) - 1));
    if (style < 5) begin
      if ($urandom_range(0, 9) == 0) v = ramp_level - int'($urandom_range(0, 3000));
      else v = ramp_level + int'($urandom_range(0, 2 * step + 200));
      if (v >= 65535 && $urandom_range(0, 3) == 0) v = int'($urandom_range(0, 4000));
    end else if (style < 8) begin
      v = thr + int'($urandom_range(0, 800)) - 400;
    end else begin
      v = int'($urandom_range(0, 65535));
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    ramp_level = v;
    return 16'(v);
  endfunction

  task automatic send_txn(op_e op, logic [15:0] sample);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    probe_sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(int unsigned idx, logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx * 4);
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits carry junk; the block must drop them
  task automatic load_config(cfg_t c);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(RegDetectEnable, {junk[31:1], c.detect_enable});
    junk = $urandom();
    write_reg(RegFilterFloor, {junk[31:16], c.filter_floor});
    junk = $urandom();
    write_reg(RegLevelThreshold, {junk[31:16], c.level_threshold});
    junk = $urandom();
    write_reg(RegSlopeStep, {junk[31:16], c.slope_step});
    junk = $urandom();
    write_reg(RegLevelLimit, {junk[31:8], c.level_count_limit});
    junk = $urandom();
    write_reg(RegSlopeLimit, {junk[31:8], c.slope_count_limit});
    if ($urandom_range(0, 3) == 0) write_reg(NumRegs + $urandom_range(0, 1), $urandom());
    cfg_now = c;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        stall = pick_idle();
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    cfg_t        c;
    int unsigned n;
    int unsigned style;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: limits forced to 5000, both counts need 3
    send_txn(OpProcess, 16'd0);
    send_txn(OpProcess, 16'hFFFF);
    send_txn(OpProcess, 16'hFFFF);
    send_txn(OpProcess, 16'hFFFF);
    send_txn(OpClear,   16'hFFFF);
    send_txn(OpProcess, 16'd6000);
    send_txn(OpProcess, 16'd2000);
    send_txn(OpProcess, 16'hFFFF);
    send_txn(OpProcess, 16'hFFFF);
    send_txn(OpProcess, 16'd4950);
    send_txn(OpProcess, 16'd4899);
    send_txn(OpProcess, 16'd1);
    send_txn(OpClear,   16'd0);
    send_txn(OpProcess, 16'd5001);
    send_txn(OpProcess, 16'd15001);

    // loaded limits, floor, slope firing; junk in upper bits and unmapped addresses
    drain_results();
    write_reg(RegDetectEnable,   32'hA5A5_0001);
    write_reg(RegFilterFloor,    32'h1234_0100);
    write_reg(RegLevelThreshold, 32'hFFFF_FFFF);
    write_reg(RegSlopeStep,      32'hDEAD_03E8);
    write_reg(RegLevelLimit,     32'h0000_FFFF);
    write_reg(RegSlopeLimit,     32'hFFFF_FF03);
    write_reg(NumRegs,           32'h0000_0000);
    write_reg(NumRegs + 1,       32'hFFFF_FFFF);
    send_txn(OpProcess, 16'h00FF);
    send_txn(OpProcess, 16'd2000);
    send_txn(OpProcess, 16'd6000);
    send_txn(OpProcess, 16'd10000);
    send_txn(OpProcess, 16'd7000);
    send_txn(OpProcess, 16'h0100);

    // zero count limits fire on every processed sample
    drain_results();
    write_reg(RegLevelLimit, 32'h0);
    send_txn(OpProcess, 16'd0);
    send_txn(OpProcess, 16'd40000);
    drain_results();
    write_reg(RegLevelLimit, 32'hFF);
    write_reg(RegSlopeLimit, 32'h0);
    send_txn(OpProcess, 16'd300);
    send_txn(OpProcess, 16'hFFFF);

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case (p)
        // level counter saturation
        0: c = '{1'b0, 16'd0, 16'd5000, 16'd5000, 8'd255, 8'd255};
        // slope counter saturation: zero step counts every flat sample
        1: c = '{1'b1, 16'd0, 16'hFFFF, 16'd0, 8'd255, 8'd255};
        2: c = '{1'b1, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0};
        3: c = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255};
        default: c = random_config();
      endcase
      load_config(c);
      if (p == HoldOffPhase) begin
        tx_idle_en   = 1'b0;
        hold_off_req = 1'b1;
      end
      n          = (p < 2) ? SatItems : PhaseItems;
      style      = $urandom_range(0, 9);
      ramp_level = int'($urandom_range(0, 4000));
      for (int i = 0; i < n; i++) begin
        if (p == 0) send_txn(OpProcess, 16'hFFFF);
        else if (p == 1) send_txn(OpProcess, 16'd30000);
        else if ($urandom_range(0, 31) == 0) send_txn(OpClear, 16'($urandom));
        else send_txn(OpProcess, next_sample(style));
      end
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
